// ===== rtl/global_lp_norm_pool_defines.svh =====
// Assertion macros for the global Lp-norm pooling block
`ifndef GLOBAL_LP_NORM_POOL_DEFINES_SVH
`define GLOBAL_LP_NORM_POOL_DEFINES_SVH
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`define GLNP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GLNP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/glnp_pkg.sv =====
// Package for the global Lp-norm pooling block
package glnp_pkg;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 63;
    localparam int ORDER_W  = 3;
    localparam int MAG_W    = 17;
    localparam int ROOT_BITS = 33;
    localparam int BIT_W    = 6;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd2;
    localparam logic [SUM_W-1:0]   SUM_MAX = {SUM_W{1'b1}};
    localparam int QUEUE_DEPTH = 2;

    typedef logic [SUM_W-1:0] t_sum;

    typedef struct packed {
        t_sum       sum;
        logic       clip;
        logic [2:0] order;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_CHECK, S_DONE, S_OUT
    } t_root_state;

    function automatic logic [2:0] order_clamp(input logic [ORDER_W-1:0] v);
        logic [2:0] r;
        r = v;
        if (v == '0) r = 3'd1;
        else if (v > 3'd4) r = 3'd4;
        return r;
    endfunction
endpackage

// ===== rtl/global_lp_norm_pool.sv =====
// Top level of the global Lp-norm pooling block
// Usage:
//   Input channel (i_valid/o_ready) takes one signed Q8.8 sample per
//   request; i_last_of_channel closes a channel. Output channel
//   (o_valid/i_ready) gives one request per channel: the floor of the
//   p-th root of sum |x|^p and a saturation flag.
//   i_norm_order_we/i_norm_order write the order p (0 acts as 1, 5..7 as 4).
// Structure and throughput:
//   Samples are accepted one per cycle while o_ready is high; the front
//   end is a three-stage pipeline (magnitude, square, accumulate).
//   The root search in the back end runs 33 bit steps, each made of p-1
//   multiplies (each done in two halves), one count step and one compare;
//   p = 1 skips the search and passes the sum through. A two-entry queue
//   absorbs channel ends.
// Reset: clears the accumulator, flag, queue and order (to 2).
// Stall: if the receiver holds i_ready low, the queue fills and then
//   o_ready drops; nothing is lost.
module global_lp_norm_pool #(
    parameter int QUEUE_DEPTH = glnp_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [glnp_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_last_of_channel,
    input  logic                          i_norm_order_we,
    input  logic [glnp_pkg::ORDER_W-1:0]  i_norm_order,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [glnp_pkg::SUM_W-1:0]    o_norm_value,
    output logic                          o_saturated
);
    import glnp_pkg::*;
`include "global_lp_norm_pool_defines.svh"

    logic [ORDER_W-1:0] r_order;
    logic  w_fv, w_fr, w_qv, w_qr;
    t_job  w_fj, w_qj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)             r_order <= ORDER_RESET;
        else if (i_norm_order_we) r_order <= i_norm_order;
    end

    glnp_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_sample, .i_last_of_channel,
        .i_norm_order(r_order), .o_job_valid(w_fv), .i_job_ready(w_fr), .o_job(w_fj)
    );

    glnp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_data(w_fj),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_qj)
    );

    glnp_root u_root (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_job(w_qj),
        .o_valid, .i_ready, .o_norm_value, .o_saturated
    );

    `GLNP_ASSERT_NXT(a_job_hold, w_fv && !w_fr, w_fv && $stable(w_fj))
    `GLNP_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_norm_value))
    `GLNP_ASSERT_IMP(a_job_order, w_qv, w_qj.order >= 3'd1 && w_qj.order <= 3'd4)
endmodule

// ===== rtl/glnp_front.sv =====
// Front end: per-sample |x|^p and saturating accumulation
module glnp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [glnp_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_last_of_channel,
    input  logic [glnp_pkg::ORDER_W-1:0]  i_norm_order,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output glnp_pkg::t_job                o_job
);
    import glnp_pkg::*;

    logic              r_v1, r_last1;
    logic [MAG_W-1:0]  r_mag1;
    logic [33:0]       r_sq;
    logic              r_v2, r_last2;
    logic [MAG_W-1:0]  r_mag2;
    logic [2:0]        r_ord;
    t_sum              r_sum, n_sum;
    logic              r_clip, n_clip;
    logic              r_jv;
    t_job              r_job;
    logic [SUM_W:0]    w_term;
    logic [SUM_W:0]    w_tot;
    logic              w_adv;

    assign w_adv   = !r_jv || i_job_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (w_adv) begin
            r_last1 <= i_last_of_channel;
            r_mag1  <= i_sample[SAMPLE_W-1]
                       ? MAG_W'(-$signed({i_sample[SAMPLE_W-1], i_sample}))
                       : MAG_W'(i_sample);
            r_sq    <= 34'(r_mag1) * 34'(r_mag1);
            r_mag2  <= r_mag1;
            r_last2 <= r_last1;
            r_ord   <= order_clamp(i_norm_order);
        end
    end

    always_comb begin
        unique case (r_ord)
            3'd1:    w_term = 64'(r_mag2);
            3'd2:    w_term = 64'(r_sq);
            3'd3:    w_term = 64'(r_sq) * 64'(r_mag2);
            default: w_term = 64'(r_sq) * 64'(r_sq);
        endcase
        w_tot = {1'b0, r_sum} + w_term;
        n_sum = r_sum;
        n_clip = r_clip;
        if (r_v2) begin
            if (w_tot[SUM_W]) begin
                n_sum = SUM_MAX;
                n_clip = 1'b1;
            end else begin
                n_sum = w_tot[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_clip <= 1'b0;
            r_jv   <= 1'b0;
        end else begin
            if (w_adv && r_v2) begin
                if (r_last2) begin
                    r_sum  <= '0;
                    r_clip <= 1'b0;
                end else begin
                    r_sum  <= n_sum;
                    r_clip <= n_clip;
                end
            end
            if (w_adv && r_v2 && r_last2) r_jv <= 1'b1;
            else if (i_job_ready)         r_jv <= 1'b0;
        end
        if (w_adv && r_v2 && r_last2)
            r_job <= '{sum: n_sum, clip: n_clip, order: r_ord};
    end

    assign o_job_valid = r_jv;
    assign o_job       = r_job;
endmodule

// ===== rtl/glnp_queue.sv =====
// Short request queue between front and back end
module glnp_queue #(
    parameter int DEPTH = glnp_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  glnp_pkg::t_job i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output glnp_pkg::t_job o_data
);
    import glnp_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
        if (w_push) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== rtl/glnp_root.sv =====
// Back end: bit-by-bit integer p-th root search (p = 1 passes the sum through)
module glnp_root (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  glnp_pkg::t_job       i_job,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [glnp_pkg::SUM_W-1:0] o_norm_value,
    output logic                 o_saturated
);
    import glnp_pkg::*;

    t_root_state r_st, n_st;
    t_job        r_job;
    logic [BIT_W-1:0] r_bit;
    logic [SUM_W-1:0] r_root;
    logic [SUM_W:0]   r_acc;
    logic [2:0]       r_k;
    logic             r_half;
    logic [64:0]      r_lo;
    logic [SUM_W-1:0] w_cand;
    logic [31:0]      w_mul_a;
    logic [ROOT_BITS-1:0] w_mul_b;
    logic [64:0]      w_prod;
    logic [96:0]      w_wide;
    logic [SUM_W:0]   w_mulres;

    assign w_cand = r_root | (SUM_W'(1) << r_bit);

    // acc * cand in two halves of acc; bit SUM_W of the result marks overflow
    assign w_mul_a  = r_half ? {1'b0, r_acc[SUM_W-1:32]} : r_acc[31:0];
    assign w_mul_b  = w_cand[ROOT_BITS-1:0];
    assign w_prod   = 65'(w_mul_a) * 65'(w_mul_b);
    assign w_wide   = {w_prod, 32'd0} + 97'(r_lo);
    assign w_mulres = (r_acc[SUM_W] || w_wide > 97'(SUM_MAX))
                      ? {1'b1, {SUM_W{1'b0}}} : {1'b0, w_wide[SUM_W-1:0]};

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (i_valid) n_st = (i_job.order == 3'd1) ? S_OUT : S_MUL;
            S_MUL:   if (r_k == 3'd1) n_st = S_CHECK;
            S_CHECK: n_st = (r_bit == '0) ? S_OUT : S_MUL;
            S_DONE:  n_st = S_OUT;
            S_OUT:   if (i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = r_st == S_IDLE;
        o_valid = r_st == S_OUT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_IDLE;
        else          r_st <= n_st;
        unique case (r_st)
            S_IDLE: begin
                r_job  <= i_job;
                r_bit  <= BIT_W'(ROOT_BITS-1);
                r_root <= (i_job.order == 3'd1) ? i_job.sum : '0;
                r_acc  <= 64'd1 << (ROOT_BITS-1);
                r_k    <= i_job.order;
                r_half <= 1'b0;
            end
            S_MUL: begin
                if (r_k != 3'd1) begin
                    if (!r_half) begin
                        r_lo   <= w_prod;
                        r_half <= 1'b1;
                    end else begin
                        r_acc  <= w_mulres;
                        r_half <= 1'b0;
                        r_k    <= r_k - 3'd1;
                    end
                end
            end
            S_CHECK: begin
                if (!r_acc[SUM_W] && r_acc[SUM_W-1:0] <= r_job.sum) r_root <= w_cand;
                r_half <= 1'b0;
                if (r_bit != '0) begin
                    r_bit <= r_bit - 1'b1;
                    r_acc <= {1'b0, (r_acc[SUM_W] || r_acc[SUM_W-1:0] > r_job.sum)
                              ? r_root | (SUM_W'(1) << (r_bit - 1'b1))
                              : w_cand | (SUM_W'(1) << (r_bit - 1'b1))};
                    r_k   <= r_job.order;
                end
            end
            default: ;
        endcase
    end

    assign o_norm_value = r_root;
    assign o_saturated  = r_job.clip;
endmodule
